// File: design/ttcw_pkg.sv
// ttcw_pkg: shared constants for the text terminal character writer
// character codes, operation and register codes, default sizes
// no dependencies

package ttcw_pkg;

	// control and fill characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// operation carried in tuser
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	// default geometry
	localparam int DEF_MAX_COLS  = 128;
	localparam int DEF_MAX_ROWS  = 32;
	localparam int DEF_TAB_WIDTH = 4;

	// register values after reset, before clamping to the geometry
	localparam int RST_COLS = 80;
	localparam int RST_ROWS = 25;

	// bus widths
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;

endpackage

// File: design/text_terminal_char_writer_unit.sv
// text_terminal_char_writer_unit: screen memory, cursor and scroll sequencer
// a put is decoded in EXEC, a read goes on through READ, a tab writes spaces
// up to its stop in TAB; a scroll copies each cell of rows 1 and below one row
// up in COPY, then blanks the bottom row in BLANK (BLANK alone on a one-row
// screen), one cell at a time through the single write port of the screen memory
// one item at a time; the next beat is taken while the previous result waits
// reset: cursor to 0, registers to 80 x 25, then a clearing pass fills all
// MAX_ROWS * MAX_COLS cells (4096 by default) with spaces, with s_tready low

module text_terminal_char_writer_unit
	import ttcw_pkg::*;
#(
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
	input  logic                 s_tuser,   // op[0]
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // cell_char[7:0], cursor_column[14:8],
	                                        // cursor_line[19:15], scrolled[20]
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [CFG_AW-1:0]    paddr,
	input  logic [CFG_DW-1:0]    pwdata,
	output logic [CFG_DW-1:0]    prdata,
	output logic                 pready
);

	// widths: counts that reach the maximum, and indexes below it
	localparam int COLW  = $clog2(MAX_COLS + 1);
	localparam int ROWW  = $clog2(MAX_ROWS + 1);
	localparam int COLIW = $clog2(MAX_COLS);
	localparam int ROWIW = $clog2(MAX_ROWS);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW0   = (COLW > ROWW) ? COLW : ROWW;
	localparam int CMPW  = (CW0 > 8) ? CW0 : 8;
	localparam int NSTOP = MAX_COLS / TAB_WIDTH + 1;

	localparam int COLS_RST = (RST_COLS > MAX_COLS) ? MAX_COLS : RST_COLS;
	localparam int ROWS_RST = (RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,  // filling the memory with spaces after reset
		ST_IDLE  = 8'b0000_0010,  // waiting for a beat
		ST_EXEC  = 8'b0000_0100,  // decode the byte, or issue the cell read
		ST_TAB   = 8'b0000_1000,  // one space per cycle up to the tab stop
		ST_READ  = 8'b0001_0000,  // cell read data is back
		ST_COPY  = 8'b0010_0000,  // scroll: move one cell up per cycle
		ST_BLANK = 8'b0100_0000,  // scroll: blank the bottom row
		ST_DONE  = 8'b1000_0000   // hand the result to the output register
	} state_t;

	state_t state_q;

	// screen memory, one byte per cell at row * MAX_COLS + col
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;

	// registers and cursor
	logic [COLW-1:0]  cols_q;
	logic [ROWW-1:0]  rows_q;
	logic [COLIW-1:0] cursor_x_q;
	logic [ROWIW-1:0] cursor_y_q;

	// item in flight
	logic       op_q;
	logic [7:0] char_q;
	logic [4:0] rrow_q;
	logic [6:0] rcol_q;
	logic [7:0] cell_q;
	logic       scrolled_q;

	// clearing and scroll counters, copy write-back stage
	logic [AW-1:0]    clr_q;
	logic [ROWIW-1:0] cp_row_q;
	logic [COLIW-1:0] cp_col_q;
	logic             cp_valid_s1;
	logic [AW-1:0]    cp_waddr_s1;

	// output register
	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	// register port decode
	logic            cfg_we;
	logic [CMPW-1:0] cfg_cols_raw;
	logic [CMPW-1:0] cfg_rows_raw;
	logic [COLW-1:0] cfg_cols;
	logic [ROWW-1:0] cfg_rows;

	// cursor arithmetic
	logic [COLW-1:0] x_inc;
	logic            wrap;
	logic            last_row;
	logic            tab_stop;
	logic            is_print;
	state_t          nl_state;

	// addresses
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] bs_addr;
	logic [AW-1:0] rd_addr;
	logic          rd_win;
	logic [AW-1:0] cp_raddr;
	logic [AW-1:0] cp_waddr;
	logic [AW-1:0] bl_addr;
	logic          col_last;
	logic          row_last;

	function automatic logic [AW-1:0] cell_addr(input logic [CMPW-1:0] row,
	                                            input logic [CMPW-1:0] col);
		return AW'(AW'(row) * AW'(MAX_COLS)) + AW'(col);
	endfunction

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// register writes complete in the access cycle; pwdata[7:0] (cols) or [5:0] (rows) clamps to 1..max
	assign cfg_we       = psel && penable && pwrite && pready;
	assign cfg_cols_raw = CMPW'(pwdata[7:0]);
	assign cfg_rows_raw = CMPW'(pwdata[5:0]);

	always_comb begin
		if (cfg_cols_raw == '0) begin
			cfg_cols = COLW'(1);
		end else if (cfg_cols_raw > CMPW'(MAX_COLS)) begin
			cfg_cols = COLW'(MAX_COLS);
		end else begin
			cfg_cols = COLW'(cfg_cols_raw);
		end
		if (cfg_rows_raw == '0) begin
			cfg_rows = ROWW'(1);
		end else if (cfg_rows_raw > CMPW'(MAX_ROWS)) begin
			cfg_rows = ROWW'(MAX_ROWS);
		end else begin
			cfg_rows = ROWW'(cfg_rows_raw);
		end
	end

	assign prdata = (paddr[2] == REG_ROWS) ? CFG_DW'(rows_q) : CFG_DW'(cols_q);

	// cursor stepping: wrap at the row end, scroll at the bottom row
	assign x_inc    = COLW'(cursor_x_q) + COLW'(1);
	assign wrap     = (x_inc == cols_q);
	assign last_row = ((ROWW'(cursor_y_q) + ROWW'(1)) == rows_q);
	assign is_print = (char_q >= CH_SPACE);

	always_comb begin
		if (!last_row) begin
			nl_state = ST_DONE;
		end else if (rows_q == ROWW'(1)) begin
			nl_state = ST_BLANK;
		end else begin
			nl_state = ST_COPY;
		end
	end

	// tab stop: the advanced column lands on a multiple of the tab width
	always_comb begin
		tab_stop = 1'b0;
		for (int k = 0; k < NSTOP; k++) begin
			if (x_inc == COLW'(k * TAB_WIDTH)) begin
				tab_stop = 1'b1;
			end
		end
	end

	assign cur_addr = cell_addr(CMPW'(cursor_y_q), CMPW'(cursor_x_q));
	assign bs_addr  = cell_addr(CMPW'(cursor_y_q), CMPW'(cursor_x_q) - CMPW'(1));
	assign rd_win   = (CMPW'(rrow_q) < CMPW'(rows_q)) && (CMPW'(rcol_q) < CMPW'(cols_q));
	assign rd_addr  = cell_addr(CMPW'(rrow_q), CMPW'(rcol_q));
	assign cp_raddr = cell_addr(CMPW'(cp_row_q), CMPW'(cp_col_q));
	assign cp_waddr = cell_addr(CMPW'(cp_row_q) - CMPW'(1), CMPW'(cp_col_q));
	assign bl_addr  = cell_addr(CMPW'(rows_q) - CMPW'(1), CMPW'(cp_col_q));
	assign col_last = ((COLW'(cp_col_q) + COLW'(1)) == cols_q);
	assign row_last = ((ROWW'(cp_row_q) + ROWW'(1)) == rows_q);

	// memory write port: the copy write-back drains before the blanking starts
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = CH_SPACE;
		priority if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (cp_valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = cp_waddr_s1;
			mem_wdata = rdata_q;
		end else if (state_q == ST_BLANK) begin
			mem_we    = 1'b1;
			mem_waddr = bl_addr;
		end else if (state_q == ST_TAB) begin
			mem_we    = 1'b1;
			mem_waddr = cur_addr;
		end else if (state_q == ST_EXEC && op_q == OP_PUT) begin
			if (char_q == CH_BS && cursor_x_q != '0) begin
				mem_we    = 1'b1;
				mem_waddr = bs_addr;
			end else if (is_print) begin
				mem_we    = 1'b1;
				mem_waddr = cur_addr;
				mem_wdata = char_q;
			end
		end
	end

	// memory read port: scroll source cell, or the requested cell
	always_comb begin
		mem_raddr = '0;
		if (state_q == ST_COPY) begin
			mem_raddr = cp_raddr;
		end else if (state_q == ST_EXEC && op_q == OP_READ && rd_win) begin
			mem_raddr = rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cols_q      <= COLW'(COLS_RST);
			rows_q      <= ROWW'(ROWS_RST);
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			op_q        <= OP_PUT;
			char_q      <= '0;
			rrow_q      <= '0;
			rcol_q      <= '0;
			cell_q      <= '0;
			scrolled_q  <= 1'b0;
			cp_row_q    <= '0;
			cp_col_q    <= '0;
			cp_valid_s1 <= 1'b0;
			cp_waddr_s1 <= '0;
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
		end else begin
			// copy write-back stage follows each scroll read
			cp_valid_s1 <= (state_q == ST_COPY);
			cp_waddr_s1 <= cp_waddr;

			// the hand-off state sets or keeps the output register itself
			if (m_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q       <= s_tuser;
						char_q     <= s_tdata[7:0];
						rrow_q     <= s_tdata[12:8];
						rcol_q     <= s_tdata[19:13];
						cell_q     <= '0;
						scrolled_q <= 1'b0;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op_q == OP_READ) begin
						state_q <= ST_READ;
					end else begin
						priority if (char_q == CH_CR) begin
							cursor_x_q <= '0;
							state_q    <= ST_DONE;
						end else if (char_q == CH_LF) begin
							cursor_x_q <= '0;
							cp_row_q   <= ROWIW'(1);
							cp_col_q   <= '0;
							if (last_row) begin
								scrolled_q <= 1'b1;
							end else begin
								cursor_y_q <= cursor_y_q + ROWIW'(1);
							end
							state_q <= nl_state;
						end else if (char_q == CH_BS) begin
							if (cursor_x_q != '0) begin
								cursor_x_q <= cursor_x_q - COLIW'(1);
							end
							state_q <= ST_DONE;
						end else if (char_q == CH_TAB) begin
							state_q <= ST_TAB;
						end else if (is_print) begin
							if (wrap) begin
								cursor_x_q <= '0;
								cp_row_q   <= ROWIW'(1);
								cp_col_q   <= '0;
								if (last_row) begin
									scrolled_q <= 1'b1;
								end else begin
									cursor_y_q <= cursor_y_q + ROWIW'(1);
								end
								state_q <= nl_state;
							end else begin
								cursor_x_q <= COLIW'(x_inc);
								state_q    <= ST_DONE;
							end
						end else begin
							// other control codes are dropped
							state_q <= ST_DONE;
						end
					end
				end
				ST_TAB: begin
					// a wrap ends the tab even short of its stop
					if (wrap) begin
						cursor_x_q <= '0;
						cp_row_q   <= ROWIW'(1);
						cp_col_q   <= '0;
						if (last_row) begin
							scrolled_q <= 1'b1;
						end else begin
							cursor_y_q <= cursor_y_q + ROWIW'(1);
						end
						state_q <= nl_state;
					end else begin
						cursor_x_q <= COLIW'(x_inc);
						if (tab_stop) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					cell_q  <= rd_win ? rdata_q : CH_SPACE;
					state_q <= ST_DONE;
				end
				ST_COPY: begin
					if (col_last) begin
						cp_col_q <= '0;
						if (row_last) begin
							state_q <= ST_BLANK;
						end else begin
							cp_row_q <= cp_row_q + ROWIW'(1);
						end
					end else begin
						cp_col_q <= cp_col_q + COLIW'(1);
					end
				end
				ST_BLANK: begin
					// hold while the last copied cell is written back
					if (!cp_valid_s1) begin
						if (col_last) begin
							state_q <= ST_DONE;
						end else begin
							cp_col_q <= cp_col_q + COLIW'(1);
						end
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {3'b000, scrolled_q, 5'(cursor_y_q), 7'(cursor_x_q),
						              cell_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// the user must send register writes only while idle; not enforced here; pull the cursor into the window
			if (cfg_we) begin
				if (paddr[2] == REG_COLS) begin
					cols_q <= cfg_cols;
					if (COLW'(cursor_x_q) >= cfg_cols) begin
						cursor_x_q <= COLIW'(cfg_cols - COLW'(1));
					end
				end else begin
					rows_q <= cfg_rows;
					if (ROWW'(cursor_y_q) >= cfg_rows) begin
						cursor_y_q <= ROWIW'(cfg_rows - ROWW'(1));
					end
				end
			end
		end
	end

	// the cursor never leaves the window once the clearing pass is over
	a_cursor_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |-> ((COLW'(cursor_x_q) < cols_q) &&
		                           (ROWW'(cursor_y_q) < rows_q)))
		else $error("cursor outside the window");

	// a scroll always leaves the cursor in column 0
	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[20]) |-> (m_tdata[14:8] == 7'd0))
		else $error("scrolled result with nonzero column");

	// the copy write-back never targets the cell being read
	a_copy_no_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid_s1 && state_q == ST_COPY) |-> (mem_raddr != cp_waddr_s1))
		else $error("scroll read and write-back hit the same cell");

	// a new result beat only comes from the hand-off state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the hand-off state");

endmodule
